// File: src/eps_pkg.sv
package eps_pkg;

    localparam int TIMESTAMP_W = 16;
    localparam int PERIOD_W    = 16;
    localparam int SPEED_W     = 24;
    localparam int MODULUS_W   = 17;
    localparam int NUMER_W     = 24;
    localparam int THRESH_W    = 16;
    localparam int ALPHA_W     = 16;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam int ALPHA_TABLE_DEPTH = 256;
    localparam int ALPHA_IDX_W       = $clog2(ALPHA_TABLE_DEPTH);
    localparam longint unsigned REF_CLOCK_HZ = 64'd1000000;
    localparam longint unsigned CUTOFF_HZ    = 64'd50;
    localparam longint unsigned TWO_PI_Q32   = 64'd26986075409;
    localparam longint unsigned ONE_Q32      = 64'd4294967296;
    localparam longint unsigned BUCKET_DEN   = 64'(2 * ALPHA_TABLE_DEPTH);
    localparam longint unsigned EXP_LIMIT    = 64'd12 << 32;

    localparam logic [MODULUS_W-1:0] TIMER_MODULUS_RESET   = 17'd65000;
    localparam logic [NUMER_W-1:0]   SPEED_NUMERATOR_RESET = 24'd7314286;
    localparam logic [THRESH_W-1:0]  STALL_THRESHOLD_RESET = 16'd1;
    localparam logic [SPEED_W-1:0]   SPEED_MAX             = 24'd8388607;

    localparam int DIV_STEPS   = NUMER_W;
    localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

    localparam int MAC_OPA_W = ALPHA_W + 2;
    localparam int MAC_PROD_W = MAC_OPA_W + SPEED_W;
    localparam int MAC_ACC_W  = MAC_PROD_W + 1;
    localparam logic [MAC_ACC_W-1:0] MAC_ROUND = MAC_ACC_W'(32768);

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [1:0] {
        REG_TIMER_MODULUS   = 2'd0,
        REG_SPEED_NUMERATOR = 2'd1,
        REG_STALL_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef logic [ALPHA_W-1:0] alpha_rom_t [ALPHA_TABLE_DEPTH];

    // exp(-2*pi*fc*p/fref) per bucket center, twelve-term series then four squarings
    function automatic alpha_rom_t build_alpha_rom();
        alpha_rom_t rom;
        longint unsigned p;
        longint unsigned x;
        longint unsigned y;
        longint unsigned term;
        longint unsigned e;
        longint unsigned a;
        for (int k = 0; k < ALPHA_TABLE_DEPTH; k++)
        begin
            p = (64'(2 * k + 1) * 64'd65536) / BUCKET_DEN;
            x = (TWO_PI_Q32 * CUTOFF_HZ) * p / REF_CLOCK_HZ;
            if (x >= EXP_LIMIT)
            begin
                rom[k] = '0;
            end
            else
            begin
                y    = x >> 4;
                term = ONE_Q32;
                e    = ONE_Q32;
                for (int i = 1; i <= 12; i++)
                begin
                    term = ((term * y) >> 32) / 64'(i);
                    if ((i % 2) == 1)
                        e = e - term;
                    else
                        e = e + term;
                end
                for (int j = 0; j < 4; j++)
                begin
                    if (e > 64'hFFFF_FFFF)
                        e = 64'hFFFF_FFFF;
                    e = (e * e) >> 32;
                end
                a = (e + 64'd32768) >> 16;
                if (a > 64'd65535)
                    a = 64'd65535;
                rom[k] = a[ALPHA_W-1:0];
            end
        end
        return rom;
    endfunction

    localparam alpha_rom_t ALPHA_ROM = build_alpha_rom();

endpackage

// File: src/eps_in_if.sv
interface eps_in_if;
    import eps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [TIMESTAMP_W-1:0] timestamp;
    logic                   backward;

    modport source (output valid, output op, output timestamp, output backward, input ready);
    modport sink (input valid, input op, input timestamp, input backward, output ready);
endinterface

// File: src/eps_out_if.sv
interface eps_out_if;
    import eps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] filtered_speed_out;
    logic [PERIOD_W-1:0]       period_out;
    logic                      stalled;

    modport source (output valid, output filtered_speed_out, output period_out,
                    output stalled, input ready);
    modport sink (input valid, input filtered_speed_out, input period_out,
                  input stalled, output ready);
endinterface

// File: src/eps_divider.sv
module eps_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [eps_pkg::NUMER_W-1:0]  dividend,
    input  logic [eps_pkg::PERIOD_W-1:0] divisor,
    output logic                         done,
    output logic [eps_pkg::NUMER_W-1:0]  quotient
);
    import eps_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_COUNT_W-1:0] count_reg, count_next;
    logic [PERIOD_W-1:0]    rem_reg, rem_next;
    logic [NUMER_W-1:0]     quo_reg, quo_next;
    logic [PERIOD_W-1:0]    div_reg, div_next;

    logic [PERIOD_W:0]   rem_shift;
    logic [PERIOD_W+1:0] diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift  = {rem_reg, quo_reg[NUMER_W-1]};
        diff       = {1'b0, rem_shift} - {2'b00, div_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[PERIOD_W+1])
            begin
                rem_next = diff[PERIOD_W-1:0];
                quo_next = {quo_reg[NUMER_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[PERIOD_W-1:0];
                quo_next = {quo_reg[NUMER_W-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_COUNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: src/eps_mac.sv
module eps_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [eps_pkg::ALPHA_W-1:0]        alpha,
    input  logic signed [eps_pkg::SPEED_W-1:0] hist,
    input  logic signed [eps_pkg::SPEED_W-1:0] raw,
    output logic                               done,
    output logic signed [eps_pkg::SPEED_W-1:0] result
);
    import eps_pkg::*;

    logic                        busy_reg, busy_next;
    logic                        step_reg, step_next;
    logic                        done_reg, done_next;
    logic [ALPHA_W-1:0]          alpha_reg, alpha_next;
    logic signed [SPEED_W-1:0]   hist_reg, hist_next;
    logic signed [SPEED_W-1:0]   raw_reg, raw_next;
    logic signed [MAC_ACC_W-1:0] acc_reg, acc_next;

    logic [ALPHA_W:0]             comp;
    logic signed [MAC_OPA_W-1:0]  mul_a;
    logic signed [SPEED_W-1:0]    mul_b;
    logic signed [MAC_PROD_W-1:0] product;

    // first pass alpha*hist, second pass (1-alpha)*raw, on one multiplier
    always_comb
    begin
        comp    = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha_reg};
        mul_a   = step_reg ? $signed({1'b0, comp}) : $signed({2'b00, alpha_reg});
        mul_b   = step_reg ? raw_reg : hist_reg;
        product = mul_a * mul_b;

        busy_next  = busy_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        alpha_next = alpha_reg;
        hist_next  = hist_reg;
        raw_next   = raw_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = 1'b0;
            alpha_next = alpha;
            hist_next  = hist;
            raw_next   = raw;
            acc_next   = $signed(MAC_ROUND);
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + MAC_ACC_W'(product);
            step_next = 1'b1;
            if (step_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
        hist_reg  <= hist_next;
        raw_reg   <= raw_next;
        acc_reg   <= acc_next;
    end

    // floor of acc / 65536
    assign done   = done_reg;
    assign result = acc_reg[ALPHA_W +: SPEED_W];
endmodule

// File: src/encoder_period_speed_filter.sv
// Encoder speed estimator. A capture beat (op 0) takes the timer period since the
// previous capture, divides speed_numerator by it into a signed speed in 1/256 rpm and
// smooths it with a cutoff-dependent factor; a tick beat (op 1) zeroes the speed when
// the latest stamp moved fewer counts than stall_threshold since the last tick. Each
// beat gives one result beat. A capture goes from acceptance through the 24-step serial
// divider and then the two-pass shared multiply-accumulate to its result; a tick goes
// from its calculation step straight to the output write. One beat is worked on at a
// time, and the next is accepted once the result is in the output register.
module encoder_period_speed_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    eps_in_if.sink                         in_ch,
    eps_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [eps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [eps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [eps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import eps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CALC   = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_WRITE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [MODULUS_W-1:0] modulus_reg, modulus_next;
    logic [NUMER_W-1:0]   numer_reg, numer_next;
    logic [THRESH_W-1:0]  thresh_reg, thresh_next;

    logic                      op_reg, op_next;
    logic [TIMESTAMP_W-1:0]    stamp_reg, stamp_next;
    logic                      back_reg, back_next;
    logic [TIMESTAMP_W-1:0]    latest_reg, latest_next;
    logic [PERIOD_W-1:0]       period_reg, period_next;
    logic signed [SPEED_W-1:0] smoothed_reg, smoothed_next;
    logic [TIMESTAMP_W-1:0]    at_tick_reg, at_tick_next;
    logic                      stalled_reg, stalled_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0] out_speed_reg, out_speed_next;
    logic [PERIOD_W-1:0]       out_period_reg, out_period_next;
    logic                      out_stalled_reg, out_stalled_next;

    logic                      cfg_write;
    cfg_reg_t                  cfg_sel;
    logic                      in_fire;
    logic signed [MODULUS_W+1:0] wrap_sum;
    logic signed [MODULUS_W+1:0] tick_diff;
    logic signed [MODULUS_W+1:0] tick_dist;
    logic [PERIOD_W-1:0]       wrap_period;

    logic                      div_start;
    logic                      div_done;
    logic [NUMER_W-1:0]        div_quotient;
    logic [SPEED_W-1:0]        raw_mag;
    logic signed [SPEED_W-1:0] raw_speed;
    logic [ALPHA_W-1:0]        alpha;
    logic                      mac_done;
    logic signed [SPEED_W-1:0] mac_result;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

    always_comb
    begin
        modulus_next = modulus_reg;
        numer_next   = numer_reg;
        thresh_next  = thresh_reg;
        prdata       = '0;
        case (cfg_sel)
            REG_TIMER_MODULUS:
            begin
                prdata = CFG_DATA_W'(modulus_reg);
                if (cfg_write)
                    modulus_next = pwdata[MODULUS_W-1:0];
            end
            REG_SPEED_NUMERATOR:
            begin
                prdata = CFG_DATA_W'(numer_reg);
                if (cfg_write)
                    numer_next = pwdata[NUMER_W-1:0];
            end
            REG_STALL_THRESHOLD:
            begin
                prdata = CFG_DATA_W'(thresh_reg);
                if (cfg_write)
                    thresh_next = pwdata[THRESH_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // datapath helpers
    assign in_fire = in_ch.valid && in_ch.ready;

    always_comb
    begin
        wrap_sum = $signed({2'b00, modulus_reg}) - $signed((MODULUS_W+2)'(latest_reg))
                 + $signed((MODULUS_W+2)'(stamp_reg));
        if (wrap_sum < 0)
            wrap_period = '0;
        else if (wrap_sum > $signed((MODULUS_W+2)'(16'hFFFF)))
            wrap_period = '1;
        else
            wrap_period = wrap_sum[PERIOD_W-1:0];

        tick_diff = $signed((MODULUS_W+2)'(latest_reg)) - $signed((MODULUS_W+2)'(at_tick_reg));
        if (tick_diff < 0)
            tick_dist = tick_diff + $signed({2'b00, modulus_reg});
        else
            tick_dist = tick_diff;
    end

    assign raw_mag   = (period_reg == '0 || div_quotient[NUMER_W-1]) ? SPEED_MAX
                     : div_quotient;
    assign raw_speed = back_reg ? -$signed(raw_mag) : $signed(raw_mag);
    assign alpha     = ALPHA_ROM[period_reg[PERIOD_W-1 -: ALPHA_IDX_W]];

    assign div_start = (state_reg == ST_CALC) && (op_reg == OP_CAPTURE);

    eps_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (numer_reg),
        .divisor  (period_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    eps_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_done),
        .alpha  (alpha),
        .hist   (smoothed_reg),
        .raw    (raw_speed),
        .done   (mac_done),
        .result (mac_result)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        stamp_next       = stamp_reg;
        back_next        = back_reg;
        latest_next      = latest_reg;
        period_next      = period_reg;
        smoothed_next    = smoothed_reg;
        at_tick_next     = at_tick_reg;
        stalled_next     = stalled_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_speed_next   = out_speed_reg;
        out_period_next  = out_period_reg;
        out_stalled_next = out_stalled_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = in_ch.op;
                    stamp_next = in_ch.timestamp;
                    back_next  = in_ch.backward;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (op_reg == OP_TICK)
                begin
                    stalled_next = 1'b0;
                    if (!tick_dist[MODULUS_W+1]
                        && tick_dist < $signed((MODULUS_W+2)'(thresh_reg)))
                    begin
                        smoothed_next = '0;
                        stalled_next  = 1'b1;
                    end
                    at_tick_next = latest_reg;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    stalled_next = 1'b0;
                    if (stamp_reg > latest_reg)
                        period_next = stamp_reg - latest_reg;
                    else if (stamp_reg < latest_reg)
                        period_next = wrap_period;
                    latest_next = stamp_reg;
                    state_next  = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_MULT;
            end
            ST_MULT:
            begin
                if (mac_done)
                begin
                    smoothed_next = mac_result;
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_speed_next   = smoothed_reg;
                    out_period_next  = period_reg;
                    out_stalled_next = stalled_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= TIMER_MODULUS_RESET;
            numer_reg     <= SPEED_NUMERATOR_RESET;
            thresh_reg    <= STALL_THRESHOLD_RESET;
            latest_reg    <= '0;
            period_reg    <= '0;
            smoothed_reg  <= '0;
            at_tick_reg   <= '0;
            stalled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            numer_reg     <= numer_next;
            thresh_reg    <= thresh_next;
            latest_reg    <= latest_next;
            period_reg    <= period_next;
            smoothed_reg  <= smoothed_next;
            at_tick_reg   <= at_tick_next;
            stalled_reg   <= stalled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        stamp_reg       <= stamp_next;
        back_reg        <= back_next;
        out_speed_reg   <= out_speed_next;
        out_period_reg  <= out_period_next;
        out_stalled_reg <= out_stalled_next;
    end

    assign in_ch.ready               = (state_reg == ST_IDLE);
    assign out_ch.valid              = out_valid_reg;
    assign out_ch.filtered_speed_out = out_speed_reg;
    assign out_ch.period_out         = out_period_reg;
    assign out_ch.stalled            = out_stalled_reg;

    // checks
    a_stall_zeroes_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.stalled |-> out_ch.filtered_speed_out == '0)
        else $error("stalled beat with nonzero speed");

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside divide phase");

    a_mac_done_in_mult: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_MULT)
        else $error("multiply-accumulate finished outside multiply phase");

    a_accept_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_CALC)
        else $error("accepted beat did not start processing");
endmodule
